>>> sv/pgd_pkg.sv
// Shared types, codes and widths for the particle grid deposition block.
// Used by particle_grid_deposition_top and the testbench; depends on nothing else.
package pgd_pkg;

    localparam int AXIS_MAX_DEF    = 32;
    localparam int GRID_POINTS_DEF = 32768;

    localparam int FRAC_W   = 24;
    localparam int VAL_W    = 32;
    localparam int SUM_W    = 48;
    localparam int SIZE_W   = 6;
    localparam int BIN_W    = 15;
    localparam int ROW_W    = 12;
    localparam int LIN_W    = 18;
    localparam int PROD_W   = FRAC_W + SIZE_W;
    localparam int PFRAC_W  = 16 + SIZE_W;
    localparam int TRUNC_W  = PROD_W - 16;
    localparam int NAXES    = 3;

    localparam int CMD_W     = 2;
    localparam int CFG_IDX_W = 3;

    localparam int S_TDATA_W = 120;
    localparam int S_TUSER_W = 3;
    localparam int M_TDATA_W = 64;
    localparam int M_TUSER_W = 2;

    localparam logic [CMD_W-1:0] CMD_DEPOSIT  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_READ     = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ_CLR = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Z = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WRAP_X = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_WRAP_Y = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_WRAP_Z = 3'd5;

    localparam logic [SIZE_W-1:0] SIZE_RESET = 6'd32;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCALE,
        S_BIN,
        S_ROW,
        S_ADDR,
        S_READ,
        S_DONE
    } t_state;

endpackage

>>> sv/pgd_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Depends on nothing; the read data holds while no read is enabled.
module pgd_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 32768
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> sv/particle_grid_deposition_top.sv
// Nearest-grid-point deposition of particle values into a 3-D grid of saturating sums.
// Depends on pgd_pkg and pgd_ram.
//
// Use: the slave stream carries one command word per transfer: a deposit of a
// value at a fractional position, a read of a bin, or a read that clears the bin.
// The master stream returns exactly one result word for each command word.
// Grid sizes and wrap modes are written through the configuration port while
// the block is idle; a change does not clear the stored sums.
// Timing: a command word is accepted only in the idle state. It then steps
// through the scale, bin, row, address, read and done states; its result is
// loaded into the output register as the done state ends, and only then is the
// next command word accepted. The read-modify-write of the sum memory, behind the
// scaling and row-major address multiplications, sets this order.
// Reset: the block runs a clearing pass that writes zero to every bin, one bin
// per cycle; no command word is taken during it, but configuration writes are.
// Stall: a finished result waits in the output register. A new command word
// is still accepted, and its result waits in the last step until the register
// is free.
module particle_grid_deposition_top
    import pgd_pkg::*;
#(
    parameter int AXIS_MAX    = AXIS_MAX_DEF,
    parameter int GRID_POINTS = GRID_POINTS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_addr,
    input  logic [SIZE_W-1:0]    i_cfg_wdata,
    input  logic                 i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    // frac_x[23:0], frac_y[47:24], frac_z[71:48], sample_value[103:72],
    // read_index[118:104], zero fill[119]
    input  logic [S_TDATA_W-1:0] i_s_axis_tdata,
    // cmd[1:0], value_missing[2]
    input  logic [S_TUSER_W-1:0] i_s_axis_tuser,
    output logic                 o_m_axis_tvalid,
    input  logic                 i_m_axis_tready,
    // bin_number[14:0], bin_sum[62:15], zero fill[63]
    output logic [M_TDATA_W-1:0] o_m_axis_tdata,
    // deposited[0], saturated[1]
    output logic [M_TUSER_W-1:0] o_m_axis_tuser
);

    localparam int ADDR_W = $clog2(GRID_POINTS);

    t_state r_state, n_state;

    logic [SIZE_W-1:0]  r_size [NAXES];
    logic [NAXES-1:0]   r_wrap;
    logic [ADDR_W-1:0]  r_clr_addr;

    logic [CMD_W-1:0]   r_cmd;
    logic               r_missing;
    logic [FRAC_W-1:0]  r_frac [NAXES];
    logic [VAL_W-1:0]   r_sample;
    logic [BIN_W-1:0]   r_ridx;

    logic signed [PROD_W-1:0] r_prod [NAXES];
    logic [PFRAC_W-1:0]       r_pfrac [NAXES];
    logic [SIZE_W-1:0]        r_bin [NAXES];
    logic [NAXES-1:0]         r_bin_ok;
    logic [ROW_W-1:0]         r_row;
    logic [LIN_W-1:0]         r_lin;
    logic                     r_hit;
    logic [ADDR_W-1:0]        r_addr;

    logic                 r_out_valid;
    logic [M_TDATA_W-1:0] r_out_data;
    logic [M_TUSER_W-1:0] r_out_user;

    logic [SIZE_W-1:0]        w_n [NAXES];
    logic signed [SIZE_W:0]   w_n_s [NAXES];
    logic signed [TRUNC_W-1:0] w_trunc [NAXES];
    logic [SIZE_W-1:0]        w_wbin [NAXES];
    logic [SIZE_W-1:0]        w_bin [NAXES];
    logic [NAXES-1:0]         w_bin_ok;

    logic                 w_accept;
    logic                 w_out_free;
    logic                 w_is_dep;
    logic                 w_is_read;
    logic                 w_lin_in_grid;
    logic                 w_ridx_in_grid;
    logic                 w_hit;
    logic [ADDR_W-1:0]    w_addr;
    logic [SUM_W-1:0]     w_rdata;
    logic [SUM_W:0]       w_add;
    logic [SUM_W-1:0]     w_sat_sum;
    logic                 w_sat;
    logic [BIN_W-1:0]     w_res_num;
    logic                 w_res_dep;
    logic [SUM_W-1:0]     w_res_sum;
    logic                 w_res_sat;

    logic                 w_we;
    logic [ADDR_W-1:0]    w_waddr;
    logic [SUM_W-1:0]     w_wdata;
    logic                 w_re;
    logic                 w_load_out;

    assign w_accept   = i_s_axis_tvalid && o_s_axis_tready;
    assign w_out_free = !r_out_valid || i_m_axis_tready;
    assign w_is_dep   = (r_cmd == CMD_DEPOSIT);
    assign w_is_read  = (r_cmd == CMD_READ) || (r_cmd == CMD_READ_CLR);

    always_comb begin
        for (int a = 0; a < NAXES; a++) begin
            if (r_size[a] == '0) begin
                w_n[a] = SIZE_W'(1);
            end else if (32'(r_size[a]) > AXIS_MAX) begin
                w_n[a] = SIZE_W'(AXIS_MAX);
            end else begin
                w_n[a] = r_size[a];
            end
            w_n_s[a] = {1'b0, w_n[a]};
        end
    end

    // Truncation toward zero differs from the floor by one for negative
    // products with a nonzero fraction; the periodic bin follows from the
    // fraction part alone plus that correction.
    always_comb begin
        for (int a = 0; a < NAXES; a++) begin
            logic c;
            logic [SIZE_W-1:0] q;
            c = r_prod[a][PROD_W-1] && (r_prod[a][15:0] != '0);
            q = r_pfrac[a][PFRAC_W-1:16] + SIZE_W'(c);
            w_trunc[a] = r_prod[a][PROD_W-1:16] + TRUNC_W'(c);
            w_wbin[a]  = (q == w_n[a]) ? '0 : q;
            if (r_wrap[a]) begin
                w_bin[a]    = w_wbin[a];
                w_bin_ok[a] = 1'b1;
            end else begin
                w_bin[a]    = w_trunc[a][SIZE_W-1:0];
                w_bin_ok[a] = !w_trunc[a][TRUNC_W-1] &&
                              (w_trunc[a][TRUNC_W-2:0] < (TRUNC_W-1)'(w_n[a]));
            end
        end
    end

    assign w_lin_in_grid  = (32'(r_lin) < GRID_POINTS);
    assign w_ridx_in_grid = (32'(r_ridx) < GRID_POINTS);

    always_comb begin
        if (w_is_dep) begin
            w_hit  = !r_missing && (&r_bin_ok) && w_lin_in_grid;
            w_addr = ADDR_W'(r_lin);
        end else begin
            w_hit  = w_is_read && w_ridx_in_grid;
            w_addr = ADDR_W'(r_ridx);
        end
    end

    assign w_add = {w_rdata[SUM_W-1], w_rdata} + (SUM_W+1)'($signed(r_sample));
    always_comb begin
        w_sat     = (w_add[SUM_W] != w_add[SUM_W-1]);
        w_sat_sum = w_add[SUM_W-1:0];
        if (w_sat) begin
            w_sat_sum = w_add[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
        end
    end

    always_comb begin
        w_res_num = '0;
        w_res_dep = 1'b0;
        w_res_sum = '0;
        w_res_sat = 1'b0;
        if (w_is_dep && r_hit) begin
            w_res_num = BIN_W'(r_addr);
            w_res_dep = 1'b1;
            w_res_sum = w_sat_sum;
            w_res_sat = w_sat;
        end else if (w_is_read) begin
            w_res_num = r_ridx;
            w_res_sum = r_hit ? w_rdata : '0;
        end
    end

    always_comb begin
        n_state         = r_state;
        o_s_axis_tready = 1'b0;
        w_we            = 1'b0;
        w_waddr         = r_addr;
        w_wdata         = '0;
        w_re            = 1'b0;
        w_load_out      = 1'b0;
        case (r_state)
            S_CLEAR: begin
                w_we    = 1'b1;
                w_waddr = r_clr_addr;
                if (r_clr_addr == ADDR_W'(GRID_POINTS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_s_axis_tready = 1'b1;
                if (i_s_axis_tvalid) begin
                    n_state = S_SCALE;
                end
            end
            S_SCALE: n_state = S_BIN;
            S_BIN:   n_state = S_ROW;
            S_ROW:   n_state = S_ADDR;
            S_ADDR:  n_state = S_READ;
            S_READ: begin
                w_re    = w_hit;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (w_out_free) begin
                    w_load_out = 1'b1;
                    w_we       = r_hit && (w_is_dep || (r_cmd == CMD_READ_CLR));
                    w_wdata    = w_is_dep ? w_sat_sum : '0;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_size[0]   <= SIZE_RESET;
            r_size[1]   <= SIZE_RESET;
            r_size[2]   <= SIZE_RESET;
            r_wrap      <= '1;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr_addr <= r_clr_addr + ADDR_W'(1);
            end
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    CFG_SIZE_X: r_size[0] <= i_cfg_wdata;
                    CFG_SIZE_Y: r_size[1] <= i_cfg_wdata;
                    CFG_SIZE_Z: r_size[2] <= i_cfg_wdata;
                    CFG_WRAP_X: r_wrap[0] <= i_cfg_wdata[0];
                    CFG_WRAP_Y: r_wrap[1] <= i_cfg_wdata[0];
                    CFG_WRAP_Z: r_wrap[2] <= i_cfg_wdata[0];
                    default: ;
                endcase
            end
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd     <= i_s_axis_tuser[1:0];
            r_missing <= i_s_axis_tuser[2];
            r_frac[0] <= i_s_axis_tdata[23:0];
            r_frac[1] <= i_s_axis_tdata[47:24];
            r_frac[2] <= i_s_axis_tdata[71:48];
            r_sample  <= i_s_axis_tdata[103:72];
            r_ridx    <= i_s_axis_tdata[118:104];
        end
        if (r_state == S_SCALE) begin
            for (int a = 0; a < NAXES; a++) begin
                r_prod[a]  <= $signed(r_frac[a]) * w_n_s[a];
                r_pfrac[a] <= PFRAC_W'(r_frac[a][15:0]) * PFRAC_W'(w_n[a]);
            end
        end
        if (r_state == S_BIN) begin
            for (int a = 0; a < NAXES; a++) begin
                r_bin[a] <= w_bin[a];
            end
            r_bin_ok <= w_bin_ok;
        end
        if (r_state == S_ROW) begin
            r_row <= ROW_W'(r_bin[1]) + ROW_W'(w_n[1]) * ROW_W'(r_bin[0]);
        end
        if (r_state == S_ADDR) begin
            r_lin <= LIN_W'(r_bin[2]) + LIN_W'(w_n[2]) * LIN_W'(r_row);
        end
        if (r_state == S_READ) begin
            r_hit  <= w_hit;
            r_addr <= w_addr;
        end
        if (w_load_out) begin
            r_out_data <= {1'b0, w_res_sum, w_res_num};
            r_out_user <= {w_res_sat, w_res_dep};
        end
    end

    pgd_ram #(
        .WIDTH(SUM_W),
        .DEPTH(GRID_POINTS)
    ) u_sums (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_waddr),
        .i_wdata(w_wdata),
        .i_re   (w_re),
        .i_raddr(w_addr),
        .o_rdata(w_rdata)
    );

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_user;

    a_out_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_DONE))
        else $error("result appeared without a finished read-modify-write");

    a_sat_needs_dep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_user[1]) |-> r_out_user[0])
        else $error("saturation flagged on a result that deposited nothing");

    a_addr_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && $past(r_state == S_DONE)) |-> $stable(r_addr))
        else $error("bin address changed between memory read and write back");

    a_no_write_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCALE || r_state == S_BIN || r_state == S_ROW ||
         r_state == S_ADDR || r_state == S_READ) |-> !w_we)
        else $error("sum memory written before the bin was read");

endmodule

>>> tb/sv/testbench.sv
// Self-checking testbench for particle_grid_deposition_top: drives command words,
// predicts every result word from its own copy of the grid, and compares them.
// Depends on pgd_pkg and the RTL of the block only.
module testbench;
    import pgd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [CMD_W-1:0]     CMD_SPARE = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd7;
    localparam longint SUM_HI = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint SUM_LO = -SUM_HI - 1;
    localparam int CYCLE_LIMIT = 400_000;
    localparam int NPHASES = 6;
    localparam int PHASE_SIZE [NPHASES][3] = '{
        '{32, 32, 32}, '{1, 1, 1}, '{0, 63, 5}, '{3, 7, 2}, '{32, 32, 32}, '{17, 1, 33}
    };
    localparam int PHASE_WRAP [NPHASES][3] = '{
        '{1, 1, 1}, '{0, 0, 0}, '{0, 1, 0}, '{1, 0, 1}, '{0, 0, 0}, '{1, 1, 0}
    };

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [FRAC_W-1:0] frac_x;
        logic [FRAC_W-1:0] frac_y;
        logic [FRAC_W-1:0] frac_z;
        logic [VAL_W-1:0]  value;
        logic              missing;
        logic [BIN_W-1:0]  read_index;
    } t_cmd_word;

    typedef struct packed {
        logic [BIN_W-1:0] bin;
        logic             dep;
        logic [SUM_W-1:0] sum;
        logic             sat;
    } t_bin_report;

    logic                 clk;
    logic                 rst_n = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_addr = '0;
    logic [SIZE_W-1:0]    cfg_wdata = '0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic [S_TUSER_W-1:0] s_tuser = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [M_TUSER_W-1:0] m_tuser;

    t_cmd_word   cmd_words_todo[$];
    t_bin_report bin_reports_due[$];
    int          hot_bins[$];
    t_cmd_word   cur_word;
    logic        in_fire = 1'b0;
    int          send_idle = 0;
    int          recv_idle = 0;
    int          errors = 0;
    int          cycles = 0;

    logic signed [SUM_W-1:0] grid_model [GRID_POINTS_DEF];
    logic [SIZE_W-1:0] size_x_q = SIZE_RESET;
    logic [SIZE_W-1:0] size_y_q = SIZE_RESET;
    logic [SIZE_W-1:0] size_z_q = SIZE_RESET;
    logic wrap_x_q = 1'b1;
    logic wrap_y_q = 1'b1;
    logic wrap_z_q = 1'b1;

    particle_grid_deposition_top i_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_addr      (cfg_addr),
        .i_cfg_wdata     (cfg_wdata),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser)
    );

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic int axis_span(logic [SIZE_W-1:0] n);
        if (n == 0) return 1;
        if (n > AXIS_MAX_DEF) return AXIS_MAX_DEF;
        return int'(n);
    endfunction

    // Bin index along one axis, or -1 when the coordinate falls off the grid.
    function automatic int axis_index(logic [FRAC_W-1:0] raw, int n, logic wrap);
        longint b;
        b = (longint'($signed(raw)) * n) / 65536;
        if (wrap) begin
            b = b % n;
            if (b < 0) b += n;
        end
        if (b < 0 || b >= n) return -1;
        return int'(b);
    endfunction

    function automatic t_bin_report grid_update(t_cmd_word w);
        t_bin_report r;
        int nx, ny, nz, bx, by, bz, bin;
        longint s;
        r = '0;
        if (w.cmd == CMD_DEPOSIT) begin
            nx = axis_span(size_x_q);
            ny = axis_span(size_y_q);
            nz = axis_span(size_z_q);
            bx = axis_index(w.frac_x, nx, wrap_x_q);
            by = axis_index(w.frac_y, ny, wrap_y_q);
            bz = axis_index(w.frac_z, nz, wrap_z_q);
            if (!w.missing && bx >= 0 && by >= 0 && bz >= 0) begin
                bin = bz + nz * (by + ny * bx);
                if (bin < GRID_POINTS_DEF) begin
                    s = longint'(grid_model[bin]) + longint'($signed(w.value));
                    if (s > SUM_HI) begin
                        s = SUM_HI;
                        r.sat = 1'b1;
                    end
                    if (s < SUM_LO) begin
                        s = SUM_LO;
                        r.sat = 1'b1;
                    end
                    grid_model[bin] = s[SUM_W-1:0];
                    r.bin = bin[BIN_W-1:0];
                    r.dep = 1'b1;
                    r.sum = s[SUM_W-1:0];
                    hot_bins = {hot_bins, bin};
                    if (hot_bins.size() > 16) void'(hot_bins.pop_front());
                end
            end
        end else if (w.cmd == CMD_READ || w.cmd == CMD_READ_CLR) begin
            r.bin = w.read_index;
            r.sum = grid_model[w.read_index];
            if (w.cmd == CMD_READ_CLR) grid_model[w.read_index] = '0;
        end
        return r;
    endfunction

    task automatic flag_mismatch(string what, longint got, longint want);
        errors++;
        if (errors <= 100)
            $display("mismatch %0d at cycle %0d, %s: got %0h, expected %0h",
                     errors, cycles, what, got, want);
    endtask

    always @(posedge clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    always @(posedge clk) begin
        t_bin_report got, want;
        in_fire = rst_n && s_tvalid && (s_tready === 1'b1);
        if (rst_n && m_tvalid === 1'b1 && m_tready) begin
            got.bin = m_tdata[BIN_W-1:0];
            got.sum = m_tdata[BIN_W +: SUM_W];
            got.dep = m_tuser[0];
            got.sat = m_tuser[1];
            if (bin_reports_due.size() == 0) begin
                flag_mismatch("unexpected result word", got.bin, 0);
            end else begin
                want = bin_reports_due.pop_front();
                if (got.bin !== want.bin) flag_mismatch("bin_number", got.bin, want.bin);
                if (got.dep !== want.dep) flag_mismatch("deposited", got.dep, want.dep);
                if (got.sum !== want.sum) flag_mismatch("bin_sum", got.sum, want.sum);
                if (got.sat !== want.sat) flag_mismatch("saturated", got.sat, want.sat);
            end
        end
        if (in_fire) bin_reports_due = {bin_reports_due, grid_update(cur_word)};
    end

    always @(negedge clk) begin
        t_cmd_word nxt;
        m_tready <= ($urandom_range(0, 99) >= recv_idle);
        if (!s_tvalid || in_fire) begin
            if (cmd_words_todo.size() != 0 && $urandom_range(0, 99) >= send_idle) begin
                nxt = cmd_words_todo.pop_front();
                cur_word <= nxt;
                s_tvalid <= 1'b1;
                s_tdata  <= {1'b0, nxt.read_index, nxt.value, nxt.frac_z, nxt.frac_y, nxt.frac_x};
                s_tuser  <= {nxt.missing, nxt.cmd};
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    task automatic queue_word(logic [CMD_W-1:0] cmd, logic [FRAC_W-1:0] fx,
                              logic [FRAC_W-1:0] fy, logic [FRAC_W-1:0] fz,
                              logic [VAL_W-1:0] value, logic missing,
                              logic [BIN_W-1:0] idx);
        t_cmd_word w;
        w = '{cmd, fx, fy, fz, value, missing, idx};
        cmd_words_todo = {cmd_words_todo, w};
    endtask

    // Mostly inside one cell, sometimes a cell or so outside, sometimes anywhere.
    function automatic logic [FRAC_W-1:0] random_frac();
        int r, v;
        r = $urandom_range(0, 9);
        if (r < 6) v = $urandom_range(0, 65535);
        else if (r < 8) v = int'($urandom_range(0, 196607)) - 65536;
        else v = $urandom;
        return v[FRAC_W-1:0];
    endfunction

    function automatic t_cmd_word random_word();
        t_cmd_word w;
        int r, v, span;
        r = $urandom_range(0, 99);
        if (r < 60) w.cmd = CMD_DEPOSIT;
        else if (r < 78) w.cmd = CMD_READ;
        else if (r < 95) w.cmd = CMD_READ_CLR;
        else w.cmd = CMD_SPARE;
        w.frac_x = random_frac();
        w.frac_y = random_frac();
        w.frac_z = random_frac();
        r = $urandom_range(0, 9);
        if (r == 0) v = 32'h7FFF_FFFF;
        else if (r == 1) v = 32'h8000_0000;
        else if (r < 4) v = $urandom;
        else v = int'($urandom_range(0, 2097152)) - 1048576;
        w.value = v;
        w.missing = ($urandom_range(0, 9) == 0);
        span = axis_span(size_x_q) * axis_span(size_y_q) * axis_span(size_z_q);
        r = $urandom_range(0, 99);
        if (r < 50 && hot_bins.size() != 0) v = hot_bins[$urandom_range(0, hot_bins.size() - 1)];
        else if (r < 85) v = $urandom_range(0, span - 1);
        else v = $urandom;
        w.read_index = v[BIN_W-1:0];
        return w;
    endfunction

    // Holds the sender until every queued word is out and every result is back.
    task automatic settle();
        while (cmd_words_todo.size() != 0 || s_tvalid || bin_reports_due.size() != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);
    endtask

    task automatic put_reg(logic [CFG_IDX_W-1:0] idx, logic [SIZE_W-1:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= data;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_SIZE_X: size_x_q = data;
            CFG_SIZE_Y: size_y_q = data;
            CFG_SIZE_Z: size_z_q = data;
            CFG_WRAP_X: wrap_x_q = data[0];
            CFG_WRAP_Y: wrap_y_q = data[0];
            CFG_WRAP_Z: wrap_z_q = data[0];
            default: ;
        endcase
    endtask

    // Wrap registers get random upper bits, which the block must ignore.
    task automatic set_grid(int sx, int sy, int sz, int wx, int wy, int wz);
        settle();
        put_reg(CFG_SIZE_X, sx[SIZE_W-1:0]);
        put_reg(CFG_SIZE_Y, sy[SIZE_W-1:0]);
        put_reg(CFG_SIZE_Z, sz[SIZE_W-1:0]);
        put_reg(CFG_WRAP_X, {5'($urandom), wx[0]});
        put_reg(CFG_WRAP_Y, {5'($urandom), wy[0]});
        put_reg(CFG_WRAP_Z, {5'($urandom), wz[0]});
    endtask

    initial begin
        int p, c, k;
        for (k = 0; k < GRID_POINTS_DEF; k++) grid_model[k] = '0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        put_reg(CFG_SPARE, 6'($urandom));
        for (p = 0; p < NPHASES; p++) begin
            if (p < 2) begin
                send_idle = 22;
                recv_idle = 67;
            end else if (p < 4) begin
                send_idle = 67;
                recv_idle = 22;
            end else begin
                send_idle = 0;
                recv_idle = 0;
            end
            set_grid(PHASE_SIZE[p][0], PHASE_SIZE[p][1], PHASE_SIZE[p][2],
                     PHASE_WRAP[p][0], PHASE_WRAP[p][1], PHASE_WRAP[p][2]);
            if (p == 0) begin
                queue_word(CMD_DEPOSIT, 24'h0, 24'h0, 24'h0, 32'h1, 1'b0, '0);
                queue_word(CMD_DEPOSIT, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 32'h7FFF_FFFF,
                           1'b0, '0);
                queue_word(CMD_DEPOSIT, 24'h800000, 24'h800000, 24'h800000, 32'h8000_0000,
                           1'b0, 15'h7FFF);
                queue_word(CMD_DEPOSIT, 24'hFFFFFF, 24'hFFF7FF, 24'h00FFFF, 32'h0001_0000,
                           1'b0, '0);
                queue_word(CMD_DEPOSIT, 24'h010000, 24'h00FFFF, 24'h020000, 32'hFFFF_FFFF,
                           1'b0, '0);
                queue_word(CMD_DEPOSIT, 24'h0, 24'h0, 24'h0, 32'h5, 1'b1, '0);
                queue_word(CMD_READ, 24'h0, 24'h0, 24'h0, 32'h0, 1'b0, 15'h0);
                queue_word(CMD_READ, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 32'hFFFF_FFFF,
                           1'b1, 15'h7FFF);
                queue_word(CMD_READ_CLR, 24'h0, 24'h0, 24'h0, 32'h0, 1'b0, 15'h0);
                queue_word(CMD_READ, 24'h0, 24'h0, 24'h0, 32'h0, 1'b0, 15'h0);
                queue_word(CMD_SPARE, 24'h123456, 24'hABCDEF, 24'h7FFFFF, 32'h7FFF_FFFF,
                           1'b0, 15'h0);
                queue_word(CMD_DEPOSIT, 24'h0, 24'h0, 24'h0, 32'h8000_0000, 1'b0, '0);
                queue_word(CMD_DEPOSIT, 24'h0, 24'h0, 24'h0, 32'h8000_0000, 1'b0, '0);
                queue_word(CMD_READ_CLR, 24'h0, 24'h0, 24'h0, 32'h0, 1'b0, 15'h7FFF);
                queue_word(CMD_READ, 24'h0, 24'h0, 24'h0, 32'h0, 1'b0, 15'h7FFF);
                queue_word(CMD_DEPOSIT, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 32'h7FFF_FFFF,
                           1'b1, 15'h7FFF);
            end
            if (p == 4) begin
                queue_word(CMD_DEPOSIT, 24'h010000, 24'h0, 24'h0, 32'h7, 1'b0, '0);
                queue_word(CMD_DEPOSIT, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 32'h9, 1'b0, '0);
                queue_word(CMD_DEPOSIT, 24'h0, 24'hFFF800, 24'h0, 32'h3, 1'b0, '0);
                queue_word(CMD_DEPOSIT, 24'h00FFFF, 24'h00FFFF, 24'h00FFFF, 32'h2, 1'b0, '0);
            end
            for (c = 0; c < 5; c++) begin
                for (k = 0; k < 58; k++) cmd_words_todo = {cmd_words_todo, random_word()};
                settle();
            end
        end

        // Every deposit lands in bin 0 here, with the largest values of both signs.
        set_grid(1, 1, 1, 1, 1, 1);
        queue_word(CMD_READ_CLR, 24'h0, 24'h0, 24'h0, 32'h0, 1'b0, 15'h0);
        for (k = 0; k < 8; k++)
            queue_word(CMD_DEPOSIT, random_frac(), random_frac(), random_frac(),
                       32'h7FFF_FFFF, 1'b0, 15'($urandom));
        queue_word(CMD_READ_CLR, 24'h0, 24'h0, 24'h0, 32'h0, 1'b0, 15'h0);
        for (k = 0; k < 8; k++)
            queue_word(CMD_DEPOSIT, random_frac(), random_frac(), random_frac(),
                       32'h8000_0000, 1'b0, 15'($urandom));
        queue_word(CMD_READ_CLR, 24'h0, 24'h0, 24'h0, 32'h0, 1'b0, 15'h0);
        settle();

        if (errors == 0 && bin_reports_due.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
